// ----- hw/rtl/line_follow_pid_steering_defines.svh -----
// Assertion macros used by the checker.
`ifndef LINE_FOLLOW_PID_STEERING_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define LFPS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also runs through reset.
`define LFPS_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hw/rtl/lfps_pkg.sv -----
package lfps_pkg;

    localparam int NEAR_W  = 10;
    localparam int BASE_W  = 8;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 26;
    localparam int OPA_W   = 27;
    localparam int OPB_W   = 17;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 5;
    localparam int SPEED_W = 7;

    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_SCALE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOWDOWN_GAIN = 3'd4;

    localparam logic signed [GAIN_W-1:0] ERROR_SCALE_RST = 16'sd256;
    localparam int LEAK_LIMIT = 10;
    localparam int SPEED_MAX  = 100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_LEAK,
        ST_MP,
        ST_MI,
        ST_MD,
        ST_MS,
        ST_SLOW,
        ST_LEFT,
        ST_RIGHT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SH8
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctrl_t;

    // Q32.16 -> integer, half away from zero, limited to 0..SPEED_MAX.
    // Any negative value ends at zero after the clamp.
    function automatic logic [SPEED_W-1:0] round_clamp(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0]    r;
        logic [ACC_W-17:0]   q;
        logic [SPEED_W-1:0]  res;
        r = ACC_W'(v) + ACC_W'(32'h8000);
        q = r[ACC_W-1:16];
        if (v[ACC_W-1]) begin
            res = '0;
        end else if (q > (ACC_W-16)'(SPEED_MAX)) begin
            res = SPEED_W'(SPEED_MAX);
        end else begin
            res = q[SPEED_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/lfps_mac.sv -----
module lfps_mac
    import lfps_pkg::*;
(
    input  logic                     aclk,
    input  mac_ctrl_t                ctrl,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [OPB_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        case (ctrl.acc_op)
            ACC_LOAD:    acc_reg <= prod_ext;
            ACC_ADD:     acc_reg <= acc_reg + prod_ext;
            ACC_ADD_SH8: acc_reg <= acc_reg + (prod_ext <<< 8);
            default:     acc_reg <= acc_reg;
        endcase
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ----- hw/rtl/line_follow_pid_steering.sv -----
// From request accept the sequencer runs ERR, LEAK, MP, MI, MD, MS, SLOW, LEFT, RIGHT, DONE in order.
// A new request is taken only in idle. There is a single 27x17 multiplier/accumulator
// that the sequencer reuses for the error scale, P, I, D and slowdown products.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (aresetn low, synchronous): registers to defaults, integral and last error to zero.
module line_follow_pid_steering
    import lfps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // near_error[9:0], far_error[19:10], base_speed[27:20]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // left_speed[6:0], right_speed[13:7]
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata
);

    state_t state_reg, state_next;

    logic signed [GAIN_W-1:0] scale_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic [GAIN_W-1:0]        slow_gain_reg;

    logic signed [NEAR_W-1:0] near_reg;
    logic [BASE_W-1:0]        base_reg;
    logic [NEAR_W-1:0]        diff_reg;
    logic signed [SUM_W-1:0]  integral_reg;
    logic signed [ERR_W-1:0]  prev_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W:0]    delta_reg;
    logic signed [ACC_W-1:0]  base_red_reg;
    logic signed [ACC_W-1:0]  tmp_reg;
    logic [SPEED_W-1:0]       left_reg;
    logic [15:0]              m_tdata_reg;
    logic                     m_tvalid_reg;

    mac_ctrl_t                mac_ctrl;
    logic signed [OPA_W-1:0]  op_a;
    logic signed [OPB_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;

    logic                     accept;
    logic                     out_free;
    logic signed [NEAR_W:0]   diff_s;
    logic signed [NEAR_W:0]   diff_abs;
    logic signed [ERR_W-1:0]  err_w;
    logic signed [ERR_W+1:0]  leak_t;
    logic signed [ERR_W+1:0]  leak_q;
    logic signed [SUM_W-1:0]  sum_w;

    lfps_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod),
        .acc  (acc)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // |near - far|
    assign diff_s   = (NEAR_W+1)'($signed(s_tdata[9:0])) - (NEAR_W+1)'($signed(s_tdata[19:10]));
    assign diff_abs = diff_s[NEAR_W] ? -diff_s : diff_s;

    // Leaky integral: trunc0((sum*128 + err)/256), zero when beyond the limit
    always_comb begin
        err_w  = $signed(prod[ERR_W-1:0]);
        leak_t = ((ERR_W+2)'(integral_reg) <<< 7) + (ERR_W+2)'(err_w);
        leak_q = (leak_t + (leak_t[ERR_W+1] ? (ERR_W+2)'(255) : (ERR_W+2)'(0))) >>> 8;
        if (leak_q > (ERR_W+2)'(LEAK_LIMIT) || leak_q < -(ERR_W+2)'(LEAK_LIMIT)) begin
            sum_w = '0;
        end else begin
            sum_w = leak_q[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        mac_ctrl.mul_en = 1'b0;
        mac_ctrl.acc_op = ACC_HOLD;
        op_a            = '0;
        op_b            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ERR;
            end
            ST_ERR: begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = OPA_W'(near_reg);
                op_b            = OPB_W'(scale_reg);
                state_next      = ST_LEAK;
            end
            ST_LEAK: begin
                state_next = ST_MP;
            end
            ST_MP: begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = OPA_W'(err_reg);
                op_b            = OPB_W'(gain_p_reg);
                state_next      = ST_MI;
            end
            ST_MI: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_LOAD;
                op_a            = OPA_W'(integral_reg);
                op_b            = OPB_W'(gain_i_reg);
                state_next      = ST_MD;
            end
            ST_MD: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_ADD_SH8;
                op_a            = OPA_W'(delta_reg);
                op_b            = OPB_W'(gain_d_reg);
                state_next      = ST_MS;
            end
            ST_MS: begin
                mac_ctrl.mul_en = 1'b1;
                mac_ctrl.acc_op = ACC_ADD;
                op_a            = OPA_W'({1'b0, diff_reg});
                op_b            = {1'b0, slow_gain_reg};
                state_next      = ST_SLOW;
            end
            ST_SLOW: begin
                state_next = ST_LEFT;
            end
            ST_LEFT: begin
                state_next = ST_RIGHT;
            end
            ST_RIGHT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Config, loop state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= ERROR_SCALE_RST;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            slow_gain_reg <= '0;
            integral_reg  <= '0;
            prev_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ERROR_SCALE:   scale_reg     <= cfg_wdata;
                    REG_GAIN_P:        gain_p_reg    <= cfg_wdata;
                    REG_GAIN_I:        gain_i_reg    <= cfg_wdata;
                    REG_GAIN_D:        gain_d_reg    <= cfg_wdata;
                    REG_SLOWDOWN_GAIN: slow_gain_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_LEAK) begin
                integral_reg <= sum_w;
            end
            if (state_reg == ST_MP) begin
                prev_reg <= err_reg;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            near_reg <= $signed(s_tdata[9:0]);
            base_reg <= s_tdata[27:20];
            diff_reg <= diff_abs[NEAR_W-1:0];
        end
        case (state_reg)
            ST_LEAK:  err_reg      <= err_w;
            ST_MP:    delta_reg    <= (ERR_W+1)'(err_reg) - (ERR_W+1)'(prev_reg);
            ST_SLOW:  base_red_reg <= ACC_W'({base_reg, 16'h0000}) - (ACC_W'(prod) <<< 8);
            ST_LEFT:  tmp_reg      <= base_red_reg - acc;
            ST_RIGHT: begin
                left_reg <= round_clamp(tmp_reg);
                tmp_reg  <= base_red_reg + acc;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {2'b00, round_clamp(tmp_reg), left_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/lfps_checker.sv -----
`include "line_follow_pid_steering_defines.svh"

module lfps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `LFPS_ASSERT(a_busy_after_req, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "ready after request")
    `LFPS_ASSERT(a_no_early_result, aclk, aresetn, (s_tvalid && s_tready) |=> !$rose(m_tvalid), "result too early")
    `LFPS_ASSERT(a_speed_range, aclk, aresetn, m_tvalid |-> (m_tdata[6:0] <= 7'd100 && m_tdata[13:7] <= 7'd100), "speed out of range")
    `LFPS_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
    `LFPS_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "valid after reset")

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (.*);

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lfps_pkg::*;

    localparam int    STALL_LIMIT = 4000;
    localparam int    SETTLE_CYCLES = 14;
    localparam longint Q16_HALF = 32768;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [BASE_W-1:0]        base;
        logic signed [NEAR_W-1:0] far;
        logic signed [NEAR_W-1:0] near;
    } frame_t;

    typedef struct packed {
        logic [SPEED_W-1:0] right;
        logic [SPEED_W-1:0] left;
    } wheel_pair_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [GAIN_W-1:0]     cfg_wdata = '0;

    // register mirror and steering state
    logic [GAIN_W-1:0] scale_q = ERROR_SCALE_RST;
    logic [GAIN_W-1:0] kp_q = '0;
    logic [GAIN_W-1:0] ki_q = '0;
    logic [GAIN_W-1:0] kd_q = '0;
    logic [GAIN_W-1:0] slow_q = '0;
    longint            leak_sum = 0;
    longint            last_err = 0;

    wheel_pair_t expected_speeds[$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    int      sink_hold = 0;
    bit      no_idle = 1'b0;

    line_follow_pid_steering u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic bit roll_idle();
        return !no_idle && ($urandom_range(99) < 9);
    endfunction

    function automatic logic [SPEED_W-1:0] to_speed(longint v);
        longint q;
        if (v < 0) begin
            return '0;
        end
        q = (v + Q16_HALF) >>> 16;
        return (q > SPEED_MAX) ? SPEED_W'(SPEED_MAX) : q[SPEED_W-1:0];
    endfunction

    function automatic wheel_pair_t predict_speeds(frame_t f);
        longint  err, lk, corr, diff, slow, base_q;
        wheel_pair_t r;
        err = longint'($signed(f.near)) * longint'($signed(scale_q));
        lk = (leak_sum * 128 + err) / 256;
        if (lk > LEAK_LIMIT || lk < -LEAK_LIMIT) begin
            lk = 0;
        end
        leak_sum = lk;
        corr = err * longint'($signed(kp_q)) + lk * longint'($signed(ki_q)) * 256
             + longint'($signed(kd_q)) * (err - last_err);
        last_err = err;
        diff = longint'($signed(f.near)) - longint'($signed(f.far));
        if (diff < 0) begin
            diff = -diff;
        end
        slow = diff * longint'(slow_q) * 256;
        base_q = longint'(f.base) * 65536;
        r.left = to_speed(base_q - slow - corr);
        r.right = to_speed(base_q - slow + corr);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 40) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        wheel_pair_t exp_s, got_s;
        if (aresetn && m_tvalid && m_tready) begin
            got_s = wheel_pair_t'(m_tdata[2*SPEED_W-1:0]);
            if (expected_speeds.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                exp_s = expected_speeds.pop_front();
                if (got_s.left !== exp_s.left) begin
                    report_mismatch($sformatf("left_speed got %0d exp %0d",
                                              got_s.left, exp_s.left));
                end
                if (got_s.right !== exp_s.right) begin
                    report_mismatch($sformatf("right_speed got %0d exp %0d",
                                              got_s.right, exp_s.right));
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_speeds.push_back(predict_speeds(frame_t'(s_tdata[27:0])));
        end
        if (aresetn && cfg_wr_en) begin
            case (cfg_addr)
                REG_ERROR_SCALE:   scale_q = cfg_wdata;
                REG_GAIN_P:        kp_q = cfg_wdata;
                REG_GAIN_I:        ki_q = cfg_wdata;
                REG_GAIN_D:        kd_q = cfg_wdata;
                REG_SLOWDOWN_GAIN: slow_q = cfg_wdata;
                default: ;
            endcase
        end
    end

    // result side: random stalls, plus commanded long hold-offs
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_tready = 1'b0;
            sink_hold--;
        end else begin
            m_tready = !roll_idle();
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("line_follow_pid_steering test failed");
            $finish;
        end
    end

    task automatic send_frame(input int near, input int far, input int base);
        @(negedge aclk);
        while (roll_idle()) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {4'b0, BASE_W'(base), NEAR_W'(far), NEAR_W'(near)};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_speeds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_settings(input logic [GAIN_W-1:0] scale, kp, ki, kd, slow);
        wait_results();
        set_register(REG_ERROR_SCALE, scale);
        set_register(REG_GAIN_P, kp);
        set_register(REG_GAIN_I, ki);
        set_register(REG_GAIN_D, kd);
        set_register(REG_SLOWDOWN_GAIN, slow);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(int span);
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return GAIN_W'($urandom);
            default: return GAIN_W'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic int pick_offset();
        if ($urandom_range(9) < 6) begin
            return int'($urandom_range(48)) - 24;
        end
        return int'($urandom_range(1023)) - 512;
    endfunction

    task automatic test_directed();
        // defaults: speeds follow base, clamped
        apply_settings(ERROR_SCALE_RST, 0, 0, 0, 0);
        send_frame(511, -512, 255);
        send_frame(-512, 511, 0);
        send_frame(0, 0, 100);
        send_frame(0, 0, 37);
        // half-unit correction rounds away from zero
        apply_settings(ERROR_SCALE_RST, 16'd128, 0, 0, 0);
        send_frame(1, 1, 50);
        send_frame(-1, -1, 50);
        // leaky integral build-up, overflow clear, truncation of negatives
        apply_settings(ERROR_SCALE_RST, 0, 16'd256, 0, 0);
        send_frame(4, 4, 50);
        send_frame(4, 4, 50);
        send_frame(4, 4, 50);
        send_frame(11, 11, 50);
        send_frame(-3, -3, 50);
        send_frame(-11, -11, 50);
        send_frame(3, 3, 50);
        // derivative on steps
        apply_settings(ERROR_SCALE_RST, 0, 0, 16'd256, 0);
        send_frame(20, 20, 60);
        send_frame(-20, -20, 60);
        // slowdown by near/far spread
        apply_settings(ERROR_SCALE_RST, 0, 0, 0, 16'd128);
        send_frame(3, 0, 60);
        send_frame(-512, 511, 255);
        apply_settings(ERROR_SCALE_RST, 0, 0, 0, 16'hffff);
        send_frame(0, 1, 255);
        // register extremes
        apply_settings(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 0);
        send_frame(511, 511, 255);
        send_frame(-512, -512, 0);
        apply_settings(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
        send_frame(-512, 0, 128);
        // writes to unmapped indexes change nothing
        wait_results();
        for (int a = REG_SPARE_LO; a <= REG_SPARE_HI; a++) begin
            set_register(CFG_ADDR_W'(a), GAIN_W'($urandom));
        end
        send_frame(1, -1, 90);
    endtask

    task automatic test_random_settings(input int phases, input int items);
        logic [GAIN_W-1:0] sd;
        for (int ph = 0; ph < phases; ph++) begin
            if (ph == 0) begin
                apply_settings(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
            end else if (ph == 1) begin
                apply_settings(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
            end else begin
                sd = ($urandom_range(4) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(96));
                apply_settings(pick_gain(512), pick_gain(64), pick_gain(256),
                               pick_gain(64), sd);
                if ($urandom_range(2) == 0) begin
                    set_register(CFG_ADDR_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
                                 GAIN_W'($urandom));
                end
            end
            for (int n = 0; n < items; n++) begin
                send_frame(pick_offset(), pick_offset(), $urandom_range(255));
            end
        end
    endtask

    task automatic test_backpressure();
        apply_settings(ERROR_SCALE_RST, 16'd40, 16'd64, 16'd32, 16'd8);
        send_frame(pick_offset(), pick_offset(), $urandom_range(255));
        sink_hold = 300;
        for (int n = 0; n < 30; n++) begin
            send_frame(pick_offset(), pick_offset(), $urandom_range(255));
        end
        // sender pause until the pipe drains
        wait_results();
        for (int n = 0; n < 20; n++) begin
            send_frame(pick_offset(), pick_offset(), $urandom_range(255));
        end
    endtask

    task automatic test_no_idle(input int items);
        apply_settings(pick_gain(512), pick_gain(64), pick_gain(256), pick_gain(64),
                       GAIN_W'($urandom_range(64)));
        no_idle = 1'b1;
        for (int n = 0; n < items; n++) begin
            send_frame(pick_offset(), pick_offset(), $urandom_range(255));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_settings(12, 120);
        test_backpressure();
        test_no_idle(250);

        wait_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_speeds.size() == 0) begin
            $display("line_follow_pid_steering test passed");
        end else begin
            $display("line_follow_pid_steering test failed");
        end
        $finish;
    end

endmodule
